>>> rtl/core/hsfd_pkg.sv
package hsfd_pkg;

    // crc-8 over each two-byte word
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // conversion scale factors, full scale of a raw word is 65535
    localparam logic [7:0]  TEMP_SPAN   = 8'd175;
    localparam logic [7:0]  TEMP_OFFSET = 8'd45;
    localparam logic [6:0]  HUM_SPAN    = 7'd100;
    localparam logic [15:0] RAW_FULL    = 16'hFFFF;

    // product widths: 175*65535 fits 24 bits, 100*65535 fits 23 bits
    localparam int TEMP_PROD_W = 24;
    localparam int HUM_PROD_W  = 23;

    // position of the next byte within a reply frame
    typedef enum logic [5:0] {
        POS_T_HI  = 6'b000001,
        POS_T_LO  = 6'b000010,
        POS_T_CRC = 6'b000100,
        POS_H_HI  = 6'b001000,
        POS_H_LO  = 6'b010000,
        POS_H_CRC = 6'b100000
    } hsfd_pos_t;

    // scaled raw words handed from the frame tracker to the converter
    typedef struct packed {
        logic                   crc_ok;
        logic [TEMP_PROD_W-1:0] temp_prod;
        logic [HUM_PROD_W-1:0]  hum_prod;
    } hsfd_prod_t;

    // one byte through the msb-first crc, eight shift steps
    function automatic logic [7:0] crc_absorb(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/hsfd_frame.sv
module hsfd_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  logic [7:0]         rx_byte,
    input  logic               frame_first,
    input  logic               prod_take,
    output logic               prod_valid,
    output hsfd_pkg::hsfd_prod_t prod
);

    hsfd_pkg::hsfd_pos_t  pos_reg, pos_next, pos_eff;
    logic [7:0]           crc_reg, crc_next;
    logic [15:0]          temp_word_reg, temp_word_next;
    logic                 temp_good_reg, temp_good_next;
    logic [7:0]           hum_hi_reg, hum_hi_next;
    logic [7:0]           hum_lo_reg, hum_lo_next;
    logic                 prod_valid_reg, prod_valid_next;
    hsfd_pkg::hsfd_prod_t prod_reg, prod_next;
    logic                 accept;
    logic [31:0]          temp_mul;
    logic [31:0]          hum_mul;

    assign byte_ready = !prod_valid_reg || prod_take;
    assign accept     = byte_valid && byte_ready;
    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

    // constant-coefficient scaling of the stored raw words
    assign temp_mul = 32'(temp_word_reg) * 32'(hsfd_pkg::TEMP_SPAN);
    assign hum_mul  = 32'({hum_hi_reg, hum_lo_reg}) * 32'(hsfd_pkg::HUM_SPAN);

    always_comb
    begin
        pos_eff         = frame_first ? hsfd_pkg::POS_T_HI : pos_reg;
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        temp_word_next  = temp_word_reg;
        temp_good_next  = temp_good_reg;
        hum_hi_next     = hum_hi_reg;
        hum_lo_next     = hum_lo_reg;
        prod_valid_next = prod_valid_reg && !prod_take;
        prod_next       = prod_reg;
        if (accept)
        begin
            case (pos_eff)
                hsfd_pkg::POS_T_LO:
                begin
                    crc_next       = hsfd_pkg::crc_absorb(crc_reg, rx_byte);
                    temp_word_next = {temp_word_reg[15:8], rx_byte};
                    pos_next       = hsfd_pkg::POS_T_CRC;
                end
                hsfd_pkg::POS_T_CRC:
                begin
                    temp_good_next = (crc_reg == rx_byte);
                    crc_next       = hsfd_pkg::CRC_INIT;
                    pos_next       = hsfd_pkg::POS_H_HI;
                end
                hsfd_pkg::POS_H_HI:
                begin
                    crc_next    = hsfd_pkg::crc_absorb(crc_reg, rx_byte);
                    hum_hi_next = rx_byte;
                    pos_next    = hsfd_pkg::POS_H_LO;
                end
                hsfd_pkg::POS_H_LO:
                begin
                    crc_next    = hsfd_pkg::crc_absorb(crc_reg, rx_byte);
                    hum_lo_next = rx_byte;
                    pos_next    = hsfd_pkg::POS_H_CRC;
                end
                hsfd_pkg::POS_H_CRC:
                begin
                    prod_valid_next  = 1'b1;
                    prod_next.crc_ok = temp_good_reg && (crc_reg == rx_byte);
                    prod_next.temp_prod = temp_mul[hsfd_pkg::TEMP_PROD_W-1:0];
                    prod_next.hum_prod  = hum_mul[hsfd_pkg::HUM_PROD_W-1:0];
                    crc_next = hsfd_pkg::CRC_INIT;
                    pos_next = hsfd_pkg::POS_T_HI;
                end
                default:
                begin
                    // first byte of a frame, also any unknown position
                    crc_next       = hsfd_pkg::crc_absorb(hsfd_pkg::CRC_INIT, rx_byte);
                    temp_word_next = {rx_byte, 8'h00};
                    pos_next       = hsfd_pkg::POS_T_LO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= hsfd_pkg::POS_T_HI;
            crc_reg        <= hsfd_pkg::CRC_INIT;
            temp_word_reg  <= '0;
            temp_good_reg  <= 1'b0;
            hum_hi_reg     <= '0;
            hum_lo_reg     <= '0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            temp_word_reg  <= temp_word_next;
            temp_good_reg  <= temp_good_next;
            hum_hi_reg     <= hum_hi_next;
            hum_lo_reg     <= hum_lo_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

>>> rtl/core/hsfd_convert.sv
module hsfd_convert (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 prod_valid,
    input  hsfd_pkg::hsfd_prod_t prod,
    output logic                 prod_take,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 reading_valid,
    output logic signed [8:0]    temperature_c,
    output logic [6:0]           humidity_pct
);

    logic              result_valid_reg, result_valid_next;
    logic              ok_reg, ok_next;
    logic signed [8:0] temp_reg, temp_next;
    logic [6:0]        hum_reg, hum_next;
    logic [7:0]        t_hi;
    logic [6:0]        h_hi;
    logic [16:0]       t_rem0, h_rem0;
    logic [7:0]        t_quot;
    logic [6:0]        h_quot;
    logic              t_rem_nz;
    logic signed [8:0] t_val;

    assign prod_take     = !result_valid_reg || result_ready;
    assign result_valid  = result_valid_reg;
    assign reading_valid = ok_reg;
    assign temperature_c = temp_reg;
    assign humidity_pct  = hum_reg;

    // x / 65535: with x = hi*65536 + lo, quotient hi and remainder hi + lo,
    // one correction step since hi stays small
    always_comb
    begin
        t_hi   = prod.temp_prod[23:16];
        t_rem0 = 17'(t_hi) + 17'(prod.temp_prod[15:0]);
        if (t_rem0 >= 17'(hsfd_pkg::RAW_FULL))
        begin
            t_quot   = t_hi + 8'd1;
            t_rem_nz = (t_rem0 != 17'(hsfd_pkg::RAW_FULL));
        end
        else
        begin
            t_quot   = t_hi;
            t_rem_nz = (t_rem0 != 17'd0);
        end

        h_hi   = prod.hum_prod[22:16];
        h_rem0 = 17'(h_hi) + 17'(prod.hum_prod[15:0]);
        if (h_rem0 >= 17'(hsfd_pkg::RAW_FULL))
        begin
            h_quot = h_hi + 7'd1;
        end
        else
        begin
            h_quot = h_hi;
        end

        // offset, rounding negatives toward zero
        t_val = $signed({1'b0, t_quot}) - $signed({1'b0, hsfd_pkg::TEMP_OFFSET});
        if ((t_quot < hsfd_pkg::TEMP_OFFSET) && t_rem_nz)
        begin
            t_val = t_val + 9'sd1;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        ok_next           = ok_reg;
        temp_next         = temp_reg;
        hum_next          = hum_reg;
        if (prod_take)
        begin
            result_valid_next = prod_valid;
            if (prod_valid)
            begin
                ok_next   = prod.crc_ok;
                temp_next = prod.crc_ok ? t_val : 9'sd0;
                hum_next  = prod.crc_ok ? h_quot : 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        temp_reg <= temp_next;
        hum_reg  <= hum_next;
    end

endmodule

>>> rtl/core/humidity_sensor_frame_decoder.sv
// byte six of a frame fills the product register; the converter registers the reading
// throughput: one byte per cycle while byte_ready is high, set by the byte-wide crc step
// and two-register path; bytes one to five only update frame state and give no reading
// reset (rst_n low, asynchronous): byte position to frame start, crc to 0xff,
// raw words and crc flag cleared, both pipeline registers emptied
module humidity_sensor_frame_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        rx_byte,
    input  logic              frame_first,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              reading_valid,
    output logic signed [8:0] temperature_c,
    output logic [6:0]        humidity_pct
);

    // scaled words from the frame tracker, one entry deep
    logic                 prod_valid;
    logic                 prod_take;
    hsfd_pkg::hsfd_prod_t prod;

    // frame tracker: byte position, running crc, raw words, and on the
    // final crc byte the scaled words go into the product register
    hsfd_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .rx_byte     (rx_byte),
        .frame_first (frame_first),
        .prod_take   (prod_take),
        .prod_valid  (prod_valid),
        .prod        (prod)
    );

    // converter: divide by full scale, apply offset, hold the reading
    // request until the consumer takes it
    hsfd_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .prod_valid    (prod_valid),
        .prod          (prod),
        .prod_take     (prod_take),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .reading_valid (reading_valid),
        .temperature_c (temperature_c),
        .humidity_pct  (humidity_pct)
    );

endmodule

>>> rtl/core/hsfd_checker.sv
module hsfd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              byte_valid,
    input logic              byte_ready,
    input logic [7:0]        rx_byte,
    input logic              frame_first,
    input logic              result_valid,
    input logic              result_ready,
    input logic              reading_valid,
    input logic signed [8:0] temperature_c,
    input logic [6:0]        humidity_pct
);

    // a stalled reading holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(reading_valid)
            && $stable(temperature_c) && $stable(humidity_pct))
    else $error("stalled reading changed");

    // failed crc gives zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !reading_valid |-> temperature_c == 9'sd0 && humidity_pct == 7'd0)
    else $error("failed reading has nonzero fields");

    // good reading stays within sensor range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && reading_valid |-> humidity_pct <= 7'd100
            && temperature_c >= -9'sd45 && temperature_c <= 9'sd130)
    else $error("reading out of range");

    // empty output never blocks incoming bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> byte_ready)
    else $error("byte stalled with empty output");

    // a waiting request keeps its byte and flag
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(rx_byte)
            && $stable(frame_first))
    else $error("waiting request changed");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (.*);
